// ===== design/opr_pkg.sv =====
// ----------------------------------------------------------------------------
// opr_pkg
// Shared constants and types for the optimal page replacement fault counter.
// ----------------------------------------------------------------------------
package opr_pkg;

  localparam int unsigned DEF_MAX_FRAMES = 16;
  localparam int unsigned DEF_MAX_REFS   = 1024;
  localparam int unsigned DEF_PAGE_BITS  = 16;

  localparam int unsigned FAULT_W   = 11;
  localparam int unsigned FRAMES_W  = 5;
  localparam int unsigned APB_DW    = 32;
  localparam int unsigned APB_AW    = 3;

  localparam logic [FRAMES_W-1:0] FRAMES_RESET = 5'd4;

  // register index, taken from paddr[2]
  localparam logic REG_FRAMES_IN_USE = 1'b0;

  typedef struct packed {
    logic clear_valid;
    logic clear_found;
    logic scan_en;
    logic load_en;
    logic use_empty;
  } cell_ctrl_t;

  typedef struct packed {
    logic empty_taken;
    logic unfound_taken;
  } cell_chain_t;

endpackage

// ===== design/optimal_page_replacement_faults_core.sv =====
// Load: one reference per cycle; up to MAX_REFS go to the reference memory.
// Run: starts after the last reference; a hit or free-frame miss passes through
//   the fetch and check states, and a miss with all frames full adds the
//   one-word-per-cycle forward scan of the reference memory for a victim.
// Result goes through the done state into the output register, once it is free.
// Reset: frames empty, reference count and faults zero, frames_in_use = 4.
// ----------------------------------------------------------------------------
// optimal_page_replacement_faults_core
// Collects a page reference string and counts faults under optimal
// replacement using a row of frame cells and a sequencer.
// ----------------------------------------------------------------------------
module optimal_page_replacement_faults_core #(
  parameter int unsigned MAX_FRAMES = opr_pkg::DEF_MAX_FRAMES,
  parameter int unsigned MAX_REFS   = opr_pkg::DEF_MAX_REFS,
  parameter int unsigned PAGE_BITS  = opr_pkg::DEF_PAGE_BITS
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [opr_pkg::APB_AW-1:0]   paddr,
  input  logic [opr_pkg::APB_DW-1:0]   pwdata,
  output logic [opr_pkg::APB_DW-1:0]   prdata,
  output logic                         pready,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [PAGE_BITS-1:0]         page_number_i,
  input  logic                         last_reference_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [opr_pkg::FAULT_W-1:0]  fault_count_o
);
  import opr_pkg::*;

  localparam int unsigned ADDR_W = $clog2(MAX_REFS);
  localparam int unsigned CNT_W  = $clog2(MAX_REFS + 1);
  localparam int unsigned FR_W   = $clog2(MAX_FRAMES + 1);

  localparam logic [CNT_W-1:0] REFS_LIMIT = CNT_W'(MAX_REFS);
  localparam logic [FR_W-1:0]  FR_LIMIT   = FR_W'(MAX_FRAMES);

  localparam logic [2:0] ST_LOAD  = 3'd0;
  localparam logic [2:0] ST_INIT  = 3'd1;
  localparam logic [2:0] ST_FETCH = 3'd2;
  localparam logic [2:0] ST_CHECK = 3'd3;
  localparam logic [2:0] ST_SCAN  = 3'd4;
  localparam logic [2:0] ST_DONE  = 3'd5;

  logic [2:0]           state_q, state_d;
  logic [FRAMES_W-1:0]  frames_q;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic [CNT_W-1:0]     pos_q, pos_d;
  logic [CNT_W-1:0]     scan_q, scan_d;
  logic                 pend_q, pend_d;
  logic [FR_W-1:0]      found_cnt_q, found_cnt_d;
  logic [CNT_W-1:0]     faults_q, faults_d;
  logic [PAGE_BITS-1:0] cur_page_q, cur_page_d;
  logic                 out_valid_q, out_valid_d;
  logic [FAULT_W-1:0]   out_count_q, out_count_d;

  logic [PAGE_BITS-1:0] ref_mem [MAX_REFS];
  logic [PAGE_BITS-1:0] rd_data_q;
  logic [ADDR_W-1:0]    rd_addr;
  logic                 wr_en;

  logic [FR_W-1:0]      nfr;
  logic                 in_xfer;
  logic                 cfg_wr;
  logic                 scan_done;
  logic                 fault_now;
  logic [CNT_W-1:0]     pos_next;

  cell_ctrl_t           ctrl;
  logic [PAGE_BITS-1:0] probe_page;
  logic [PAGE_BITS-1:0] load_page;
  cell_chain_t          chain [MAX_FRAMES+1];
  logic [MAX_FRAMES-1:0] hit;
  logic [MAX_FRAMES-1:0] match;
  logic                 any_hit;
  logic                 any_match;
  logic                 any_empty;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_FRAMES_IN_USE) begin
      prdata = APB_DW'(frames_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frames_q <= FRAMES_RESET;
    end else if (cfg_wr && paddr[2] == REG_FRAMES_IN_USE) begin
      frames_q <= pwdata[FRAMES_W-1:0];
    end
  end

  always_comb begin
    if (frames_q == '0) begin
      nfr = FR_W'(1);
    end else if (32'(frames_q) > MAX_FRAMES) begin
      nfr = FR_LIMIT;
    end else begin
      nfr = FR_W'(frames_q);
    end
  end

  // reference memory
  assign in_stall_o = (state_q != ST_LOAD);
  assign in_xfer    = in_valid_i & ~in_stall_o;
  assign wr_en      = in_xfer & (cnt_q < REFS_LIMIT);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      ref_mem[cnt_q[ADDR_W-1:0]] <= page_number_i;
    end
    rd_data_q <= ref_mem[rd_addr];
  end

  assign rd_addr = (state_q == ST_SCAN) ? scan_q[ADDR_W-1:0] : pos_q[ADDR_W-1:0];

  // frame cells
  assign chain[0] = '0;

  for (genvar j = 0; j < MAX_FRAMES; j++) begin : g_cell
    opr_cell #(
      .PAGE_BITS (PAGE_BITS)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .active_i     (32'(nfr) > j),
      .probe_page_i (probe_page),
      .load_page_i  (load_page),
      .chain_i      (chain[j]),
      .chain_o      (chain[j+1]),
      .hit_o        (hit[j]),
      .match_o      (match[j])
    );
  end

  assign any_hit   = |hit;
  assign any_match = |match;
  assign any_empty = chain[MAX_FRAMES].empty_taken;

  assign probe_page = rd_data_q;
  assign load_page  = (state_q == ST_SCAN) ? cur_page_q : rd_data_q;
  assign pos_next   = pos_q + CNT_W'(1);
  assign scan_done  = (found_cnt_q >= nfr - FR_W'(1)) || (!pend_q && scan_q >= cnt_q);

  // sequencer
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    pos_d       = pos_q;
    scan_d      = scan_q;
    pend_d      = pend_q;
    found_cnt_d = found_cnt_q;
    faults_d    = faults_q;
    cur_page_d  = cur_page_q;
    out_valid_d = out_valid_q & out_stall_i;
    out_count_d = out_count_q;
    ctrl        = '0;
    fault_now   = 1'b0;

    unique case (state_q)
      ST_LOAD: begin
        if (in_xfer) begin
          if (wr_en) begin
            cnt_d = cnt_q + CNT_W'(1);
          end
          if (last_reference_i) begin
            state_d = ST_INIT;
          end
        end
      end
      ST_INIT: begin
        ctrl.clear_valid = 1'b1;
        faults_d         = '0;
        pos_d            = '0;
        state_d          = ST_FETCH;
      end
      ST_FETCH: begin
        state_d = ST_CHECK;
      end
      ST_CHECK: begin
        cur_page_d = rd_data_q;
        if (!any_hit && any_empty) begin
          ctrl.load_en   = 1'b1;
          ctrl.use_empty = 1'b1;
          fault_now      = 1'b1;
        end else if (!any_hit) begin
          ctrl.clear_found = 1'b1;
          found_cnt_d      = '0;
          scan_d           = pos_next;
          pend_d           = 1'b0;
          state_d          = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_done) begin
          ctrl.load_en = 1'b1;
          fault_now    = 1'b1;
        end else begin
          ctrl.scan_en = pend_q;
          if (any_match) begin
            found_cnt_d = found_cnt_q + FR_W'(1);
          end
          pend_d = (scan_q < cnt_q);
          if (scan_q < cnt_q) begin
            scan_d = scan_q + CNT_W'(1);
          end
        end
      end
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_count_d = FAULT_W'(faults_q);
          cnt_d       = '0;
          state_d     = ST_LOAD;
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase

    if (fault_now && faults_q < REFS_LIMIT) begin
      faults_d = faults_q + CNT_W'(1);
    end

    // advance to the next reference after a hit or a filled miss
    if ((state_q == ST_CHECK && (any_hit || any_empty)) ||
        (state_q == ST_SCAN && scan_done)) begin
      if (pos_next >= cnt_q) begin
        state_d = ST_DONE;
      end else begin
        pos_d   = pos_next;
        state_d = ST_FETCH;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      cnt_q       <= '0;
      pos_q       <= '0;
      scan_q      <= '0;
      pend_q      <= 1'b0;
      found_cnt_q <= '0;
      faults_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      pos_q       <= pos_d;
      scan_q      <= scan_d;
      pend_q      <= pend_d;
      found_cnt_q <= found_cnt_d;
      faults_q    <= faults_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_page_q  <= cur_page_d;
    out_count_q <= out_count_d;
  end

  assign out_valid_o   = out_valid_q;
  assign fault_count_o = out_count_q;

endmodule

// ===== design/opr_cell.sv =====
// ----------------------------------------------------------------------------
// opr_cell
// One page frame: holds its page, valid and found bits, compares against the
// probed reference and takes part in the lowest-candidate priority chain.
// ----------------------------------------------------------------------------
module opr_cell #(
  parameter int unsigned PAGE_BITS = opr_pkg::DEF_PAGE_BITS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  opr_pkg::cell_ctrl_t  ctrl_i,
  input  logic                 active_i,
  input  logic [PAGE_BITS-1:0] probe_page_i,
  input  logic [PAGE_BITS-1:0] load_page_i,
  input  opr_pkg::cell_chain_t chain_i,
  output opr_pkg::cell_chain_t chain_o,
  output logic                 hit_o,
  output logic                 match_o
);
  import opr_pkg::*;

  logic [PAGE_BITS-1:0] page_q;
  logic                 valid_q, valid_d;
  logic                 found_q, found_d;
  logic                 eq;
  logic                 is_empty;
  logic                 is_unfound;
  logic                 load;

  assign eq         = (page_q == probe_page_i);
  assign hit_o      = valid_q & eq;
  assign match_o    = ctrl_i.scan_en & valid_q & ~found_q & eq;
  assign is_empty   = active_i & ~valid_q;
  assign is_unfound = active_i & ~found_q;

  assign chain_o.empty_taken   = chain_i.empty_taken | is_empty;
  assign chain_o.unfound_taken = chain_i.unfound_taken | is_unfound;

  assign load = ctrl_i.load_en & (ctrl_i.use_empty ? (is_empty & ~chain_i.empty_taken)
                                                   : (is_unfound & ~chain_i.unfound_taken));

  always_comb begin
    valid_d = valid_q;
    if (ctrl_i.clear_valid) begin
      valid_d = 1'b0;
    end else if (load) begin
      valid_d = 1'b1;
    end
    found_d = found_q;
    if (ctrl_i.clear_found) begin
      found_d = 1'b0;
    end else if (match_o) begin
      found_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      found_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
      found_q <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      page_q <= load_page_i;
    end
  end

endmodule
